// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implies");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next");

`endif

// ===== sv/wpr_pkg.sv =====
// ----------------------------------------------------------------------------
// wpr_pkg
// Types and mode codes of the wedge pattern row generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpr_pkg;

   localparam int ROW_W  = 5;
   localparam int BITS_W = 32;
   localparam int LG_W   = 3;
   localparam int K_W    = 10;

   localparam logic [2:0] MODE_STRAIGHT  = 3'd0;
   localparam logic [2:0] MODE_DIAG      = 3'd1;
   localparam logic [2:0] MODE_SLOPE_2_1 = 3'd2;
   localparam logic [2:0] MODE_SLOPE_4_1 = 3'd3;
   localparam logic [2:0] MODE_SLOPE_1_2 = 3'd4;
   localparam logic [2:0] MODE_SLOPE_1_4 = 3'd5;

   // per-request line description, held while the rows go out
   typedef struct packed {
      logic              straight;
      logic              ori;
      logic              neg;
      logic              shl;
      logic [1:0]        shamt;
      logic [K_W-1:0]    k;
      logic [LG_W-1:0]   lg;
      logic              bad;
   } wpr_ctl_type;

endpackage

// ===== sv/wpr_req_if.sv =====
// ----------------------------------------------------------------------------
// wpr_req_if
// Request channel: block size, line mode, orientation and offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wpr_req_if;
   logic             valid;
   logic             ready;
   logic [2:0]       size_log2;
   logic [2:0]       mode;
   logic             orientation;
   logic signed [6:0] offset;

   modport source (output valid, size_log2, mode, orientation, offset, input ready);
   modport sink   (input valid, size_log2, mode, orientation, offset, output ready);
endinterface

// ===== sv/wpr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// wpr_rsp_if
// Response channel: one pattern row per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  row_index;
   logic [31:0] row_bits;
   logic        last_row;
   logic        bad_mode;

   modport source (output valid, row_index, row_bits, last_row, bad_mode, input ready);
   modport sink   (input valid, row_index, row_bits, last_row, bad_mode, output ready);
endinterface

// ===== sv/wpr_row_unit.sv =====
// ----------------------------------------------------------------------------
// wpr_row_unit
// Row of column comparators, reused for every row of the pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpr_row_unit
   import wpr_pkg::*;
(
   input  wpr_ctl_type       ctl,
   input  logic [ROW_W-1:0]  row,
   output logic [BITS_W-1:0] bits
);

   logic [K_W-1:0] iu;
   logic [ROW_W:0] width;

   assign iu    = {{(K_W-ROW_W){1'b0}}, row};
   assign width = (ROW_W+1)'(1) << ctl.lg;

   for (genvar c = 0; c < BITS_W; c++) begin : g_col
      localparam logic [ROW_W-1:0] J = ROW_W'(c);
      logic [K_W-1:0] ju;
      logic [K_W-1:0] tu;
      logic [K_W-1:0] lhs;
      logic [K_W-1:0] v;
      logic           hit;

      assign ju  = {{(K_W-ROW_W){1'b0}}, J};
      assign tu  = ctl.shl ? (ju << ctl.shamt) : (ju >> ctl.shamt);
      assign v   = ctl.neg ? (ctl.k - tu) : (ctl.k + tu);
      assign lhs = ctl.ori ? ju : iu;
      assign hit = ctl.straight ? ($signed(lhs) < $signed(ctl.k))
                                : ($signed(iu) > $signed(v));
      // columns at or past the block width stay zero
      assign bits[c] = hit && !ctl.bad && ({1'b0, J} < width);
   end

endmodule

// ===== sv/wedge_pattern_rows.sv =====
// ----------------------------------------------------------------------------
// wedge_pattern_rows
// A taken request sets busy and clears the row counter; rows then go out through the
// response register, one row per cycle while the response side keeps up; W = 1 << lg rows,
// where lg is size_log2 clamped to MAX_LOG; the next request waits for the last row.
// Reset: synchronous, clears the sequencer and the response valid; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wedge_pattern_rows
   import wpr_pkg::*;
#(
   parameter int MAX_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   wpr_req_if.sink      req_ch,
   wpr_rsp_if.source    rsp_ch
);

   localparam int FLOOR_LOG = $clog2(MAX_WIDTH + 1) - 1;
   localparam logic [LG_W-1:0] MAX_LOG = LG_W'((FLOOR_LOG > 5) ? 5 : FLOOR_LOG);

   logic              busy_ff, busy_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   wpr_ctl_type       ctl_ff, ctl_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [BITS_W-1:0] rsp_bits_ff;
   logic              rsp_last_ff;
   logic              rsp_bad_ff;

   logic              req_take;
   logic              advance;
   logic              is_last;
   logic [ROW_W-1:0]  last_idx;
   logic [BITS_W-1:0] row_bits;
   logic [LG_W-1:0]   lg;
   logic [ROW_W:0]    w;
   logic [K_W-1:0]    h, q, off;
   logic [1:0]        s;

   assign req_take  = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !busy_ff;
   assign advance   = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign last_idx  = ROW_W'(((ROW_W+1)'(1) << ctl_ff.lg) - (ROW_W+1)'(1));
   assign is_last   = (row_ff == last_idx);

   // line decode of the incoming request
   always_comb begin
      lg  = (req_ch.size_log2 > MAX_LOG) ? MAX_LOG : req_ch.size_log2;
      w   = (ROW_W+1)'(1) << lg;
      off = K_W'(req_ch.offset);
      s   = 2'd0;
      ctl_in = '0;
      ctl_in.lg  = lg;
      ctl_in.ori = req_ch.orientation;
      unique case (req_ch.mode) inside
         MODE_SLOPE_2_1, MODE_SLOPE_1_2: s = 2'd1;
         MODE_SLOPE_4_1, MODE_SLOPE_1_4: s = 2'd2;
         default:                        s = 2'd0;
      endcase
      h = K_W'(w >> 1);
      q = K_W'(w >> (s + 2'd1));
      ctl_in.shamt = s;
      unique case (req_ch.mode) inside
         MODE_STRAIGHT: begin
            ctl_in.straight = 1'b1;
            ctl_in.k        = h + off;
         end
         MODE_DIAG: begin
            ctl_in.neg = req_ch.orientation;
            ctl_in.k   = req_ch.orientation ? (K_W'(w) + off) : off;
         end
         MODE_SLOPE_2_1, MODE_SLOPE_4_1, MODE_SLOPE_1_2, MODE_SLOPE_1_4: begin
            ctl_in.neg = req_ch.orientation;
            ctl_in.shl = (req_ch.mode == MODE_SLOPE_2_1) || (req_ch.mode == MODE_SLOPE_4_1);
            ctl_in.k   = req_ch.orientation ? (h + q + off) : (h - q + off);
         end
         default: ctl_in.bad = 1'b1;
      endcase
   end

   wpr_row_unit u_row (
      .ctl  (ctl_ff),
      .row  (row_ff),
      .bits (row_bits)
   );

   // row sequencer
   always_comb begin
      busy_in      = busy_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         row_in       = row_ff + ROW_W'(1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (req_take) begin
         busy_in = 1'b1;
         row_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ctl_ff <= ctl_in;
      end
      if (advance) begin
         rsp_row_ff  <= row_ff;
         rsp_bits_ff <= row_bits;
         rsp_last_ff <= is_last;
         rsp_bad_ff  <= ctl_ff.bad;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.row_index = rsp_row_ff;
   assign rsp_ch.row_bits  = rsp_bits_ff;
   assign rsp_ch.last_row  = rsp_last_ff;
   assign rsp_ch.bad_mode  = rsp_bad_ff;

   `ASSERT_IMPLIES(a_bad_rows_zero, clock, reset, rsp_valid_ff && rsp_bad_ff, rsp_bits_ff == '0)
   `ASSERT_NEXT(a_start_row_zero, clock, reset, req_take, busy_ff && (row_ff == '0))
   `ASSERT_IMPLIES(a_row_in_range, clock, reset, busy_ff, row_ff <= last_idx)
   `ASSERT_NEXT(a_last_ends_item, clock, reset, advance && is_last, !busy_ff)

endmodule
